// ----- hw/rtl/pyramid_min_path_sum_core_assert.svh -----
// ----------------------------------------------------------------------------
// pyramid min path sum assertion macros
// same-cycle and next-cycle implication checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PYRAMID_MIN_PATH_SUM_CORE_ASSERT_SVH
`define PYRAMID_MIN_PATH_SUM_CORE_ASSERT_SVH

`define PMPS_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`define PMPS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- hw/rtl/pmps_pkg.sv -----
// ----------------------------------------------------------------------------
// pmps_pkg
// shared constants, result kind codes and the emit request type
// ----------------------------------------------------------------------------
package pmps_pkg;

  localparam int MAX_LAYERS_DEF = 32;
  localparam int VALUE_BITS_DEF = 16;
  localparam int IN_W           = 16;
  localparam int CNT_W          = 14;
  localparam int CFG_W          = 6;
  localparam int OUT_W          = 21;

  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_SUM   = 2'd1,
    KIND_PATH  = 2'd2
  } kind_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [OUT_W-1:0] value;
    logic             last;
  } emit_t;

  // cells in all layers above layer k, elaboration use only
  function automatic int cells_above_f(int k);
    int acc;
    acc = 0;
    for (int i = 1; i < k; i++) acc = acc + i * i;
    return acc;
  endfunction

endpackage

// ----- hw/rtl/pmps_store.sv -----
// ----------------------------------------------------------------------------
// pmps_store
// cell value memory and best sum memory, one write and one registered read each
// ----------------------------------------------------------------------------
module pmps_store #(
  parameter int STORE_DEPTH = 11440,
  parameter int IDX_W       = 14,
  parameter int VALUE_BITS  = 16,
  parameter int SUM_W       = 22
) (
  input  logic                  clk,
  input  logic                  cell_we,
  input  logic [IDX_W-1:0]      cell_waddr,
  input  logic [VALUE_BITS-1:0] cell_wdata,
  input  logic [IDX_W-1:0]      cell_raddr,
  output logic [VALUE_BITS-1:0] cell_rdata,
  input  logic                  best_we,
  input  logic [IDX_W-1:0]      best_waddr,
  input  logic [SUM_W-1:0]      best_wdata,
  input  logic [IDX_W-1:0]      best_raddr,
  output logic [SUM_W-1:0]      best_rdata
);

  logic [VALUE_BITS-1:0] cell_mem [STORE_DEPTH];
  logic [SUM_W-1:0]      best_mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rdata <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (best_we) begin
      best_mem[best_waddr] <= best_wdata;
    end
    best_rdata <= best_mem[best_raddr];
  end

endmodule

// ----- hw/rtl/pmps_seq.sv -----
// ----------------------------------------------------------------------------
// pmps_seq
// load, bottom-up pass, head output and path walk sequencer over the two memories
// ----------------------------------------------------------------------------
module pmps_seq
  import pmps_pkg::*;
#(
  parameter int MAX_LAYERS  = 32,
  parameter int VALUE_BITS  = 16,
  parameter int STORE_DEPTH = 11440,
  parameter int IDX_W       = 14,
  parameter int SUM_W       = 22,
  parameter int LAY_W       = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [IN_W-1:0]       in_cell_value,
  input  logic [LAY_W-1:0]      layers,
  input  logic                  slot_free,
  output emit_t                 emit,
  output logic                  cell_we,
  output logic [IDX_W-1:0]      cell_waddr,
  output logic [VALUE_BITS-1:0] cell_wdata,
  output logic [IDX_W-1:0]      cell_raddr,
  input  logic [VALUE_BITS-1:0] cell_rdata,
  output logic                  best_we,
  output logic [IDX_W-1:0]      best_waddr,
  output logic [SUM_W-1:0]      best_wdata,
  output logic [IDX_W-1:0]      best_raddr,
  input  logic [SUM_W-1:0]      best_rdata
);

  localparam int TAB_W = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W = (TAB_W > CNT_W) ? TAB_W : CNT_W;
  localparam int MUL_W = 2 * LAY_W;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_BOT  = 5'b00010,
    S_MID  = 5'b00100,
    S_HEAD = 5'b01000,
    S_PATH = 5'b10000
  } state_t;

  logic [TAB_W-1:0] above_tab [MAX_LAYERS+2];

  for (genvar g = 0; g < MAX_LAYERS + 2; g++) begin : g_tab
    assign above_tab[g] = TAB_W'(cells_above_f(g));
  end

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [LAY_W-1:0] k_r, k_nxt, j_r, j_nxt, l_r, l_nxt, bj_r, bj_nxt, bl_r, bl_nxt;
  logic [IDX_W-1:0] x_r, x_nxt, c_r, c_nxt, bx_r, bx_nxt;
  logic [SUM_W-1:0] mn_r, mn_nxt;

  logic [CNT_W-1:0] cnt_inc;
  logic             last_col, last_row;
  logic [MUL_W-1:0] row_off;
  logic [IDX_W-1:0] k_idx;
  logic [SUM_W-1:0] min_fin;

  assign cnt_inc  = cnt_r + 1'b1;
  assign last_col = (l_r == k_r);
  assign last_row = (j_r == k_r);
  assign row_off  = MUL_W'(j_r - 1'b1) * MUL_W'(k_r);
  assign k_idx    = IDX_W'(k_r);
  assign min_fin  = (best_rdata < mn_r) ? best_rdata : mn_r;
  assign in_stall = (state_r != S_LOAD);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    step_nxt   = step_r;
    k_nxt      = k_r;
    j_nxt      = j_r;
    l_nxt      = l_r;
    x_nxt      = x_r;
    c_nxt      = c_r;
    mn_nxt     = mn_r;
    bj_nxt     = bj_r;
    bl_nxt     = bl_r;
    bx_nxt     = bx_r;
    cell_we    = 1'b0;
    cell_waddr = IDX_W'(cnt_r);
    cell_wdata = VALUE_BITS'(in_cell_value);
    cell_raddr = x_r;
    best_we    = 1'b0;
    best_waddr = x_r;
    best_wdata = SUM_W'(cell_rdata);
    best_raddr = c_r;
    emit       = '0;
    emit.kind  = KIND_PATH;

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cell_we = (CMP_W'(cnt_r) < CMP_W'(STORE_DEPTH));
          if (CMP_W'(cnt_inc) >= CMP_W'(above_tab[layers + 1'b1])) begin
            cnt_nxt   = '0;
            state_nxt = S_BOT;
            k_nxt     = layers;
            j_nxt     = LAY_W'(1);
            l_nxt     = LAY_W'(1);
            x_nxt     = IDX_W'(above_tab[layers]);
            step_nxt  = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end

      S_BOT, S_MID: begin
        case (step_r)
          3'd1:    best_raddr = c_r + 1'b1;
          3'd2:    best_raddr = c_r + k_idx + 1'b1;
          3'd3:    best_raddr = c_r + k_idx + IDX_W'(2);
          default: best_raddr = c_r;
        endcase
        if (step_r == 3'd1) begin
          mn_nxt = best_rdata;
        end else if (step_r == 3'd2 || step_r == 3'd3) begin
          mn_nxt = min_fin;
        end
        if ((state_r == S_BOT && step_r == 3'd1) || step_r == 3'd4) begin
          best_we    = 1'b1;
          best_wdata = (state_r == S_BOT) ? SUM_W'(cell_rdata)
                                          : SUM_W'(cell_rdata) + min_fin;
          step_nxt   = '0;
          x_nxt      = x_r + 1'b1;
          c_nxt      = last_col ? c_r + IDX_W'(2) : c_r + 1'b1;
          if (!last_col) begin
            l_nxt = l_r + 1'b1;
          end else begin
            l_nxt = LAY_W'(1);
            if (!last_row) j_nxt = j_r + 1'b1;
          end
          if (last_col && last_row) begin
            j_nxt = LAY_W'(1);
            if (k_r == LAY_W'(1)) begin
              state_nxt = S_HEAD;
            end else begin
              state_nxt = S_MID;
              k_nxt     = k_r - 1'b1;
              x_nxt     = IDX_W'(above_tab[k_r - 1'b1]);
              c_nxt     = IDX_W'(above_tab[k_r]);
            end
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      S_HEAD: begin
        best_raddr = '0;
        emit.valid = 1'b1;
        case (step_r)
          3'd0: begin
            emit.kind  = KIND_COUNT;
            emit.value = OUT_W'(layers);
          end
          3'd1: begin
            emit.kind  = KIND_SUM;
            emit.value = OUT_W'(best_rdata);
          end
          default: begin
            emit.kind  = KIND_PATH;
            emit.value = OUT_W'(1);
            emit.last  = (layers == LAY_W'(1));
          end
        endcase
        if (slot_free) begin
          if (step_r == 3'd2) begin
            step_nxt = '0;
            if (layers == LAY_W'(1)) begin
              state_nxt = S_LOAD;
            end else begin
              state_nxt = S_PATH;
              k_nxt     = LAY_W'(2);
              j_nxt     = LAY_W'(1);
              l_nxt     = LAY_W'(1);
            end
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end

      S_PATH: begin
        case (step_r)
          3'd2:    best_raddr = c_r + 1'b1;
          3'd3:    best_raddr = c_r + k_idx;
          3'd4:    best_raddr = c_r + k_idx + 1'b1;
          default: best_raddr = c_r;
        endcase
        step_nxt = step_r + 1'b1;
        case (step_r)
          3'd0: begin
            c_nxt = IDX_W'(above_tab[k_r]) + IDX_W'(row_off) + IDX_W'(l_r - 1'b1);
          end
          3'd2: begin
            mn_nxt = best_rdata;
            bj_nxt = j_r;
            bl_nxt = l_r;
            bx_nxt = c_r;
          end
          3'd3: begin
            if (best_rdata < mn_r) begin
              mn_nxt = best_rdata;
              bj_nxt = j_r;
              bl_nxt = l_r + 1'b1;
              bx_nxt = c_r + 1'b1;
            end
          end
          3'd4: begin
            if (best_rdata < mn_r) begin
              mn_nxt = best_rdata;
              bj_nxt = j_r + 1'b1;
              bl_nxt = l_r;
              bx_nxt = c_r + k_idx;
            end
          end
          3'd5: begin
            if (best_rdata < mn_r) begin
              mn_nxt = best_rdata;
              bj_nxt = j_r + 1'b1;
              bl_nxt = l_r + 1'b1;
              bx_nxt = c_r + k_idx + 1'b1;
            end
          end
          3'd6: begin
            emit.valid = 1'b1;
            emit.kind  = KIND_PATH;
            emit.value = OUT_W'({1'b0, bx_r} + 1'b1);
            emit.last  = (k_r == layers);
            step_nxt   = step_r;
            if (slot_free) begin
              step_nxt = '0;
              j_nxt    = bj_r;
              l_nxt    = bl_r;
              if (k_r == layers) begin
                state_nxt = S_LOAD;
              end else begin
                k_nxt = k_r + 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r  <= k_nxt;
    j_r  <= j_nxt;
    l_r  <= l_nxt;
    x_r  <= x_nxt;
    c_r  <= c_nxt;
    mn_r <= mn_nxt;
    bj_r <= bj_nxt;
    bl_r <= bl_nxt;
    bx_r <= bx_nxt;
  end

endmodule

// ----- hw/rtl/pyramid_min_path_sum_core.sv -----
// ----------------------------------------------------------------------------
// pyramid_min_path_sum_core
// least top-to-bottom path sum through a pyramid of square layers
// ----------------------------------------------------------------------------
// Cells are taken one per cycle and written to the cell memory. After the last
// cell the input stalls while a sequencer runs the bottom-up pass through the
// single read port of the best sum memory: each bottom-layer cell value is
// copied into it, and each cell of every upper layer takes four child reads and
// a write. It then sends the layer count, the minimum sum and one path cell
// number per layer, the path walk waiting whenever the output side stalls.
// The finished request sits in an output register, so loading of the next
// pyramid starts while the last result still waits.
`include "pyramid_min_path_sum_core_assert.svh"

module pyramid_min_path_sum_core
  import pmps_pkg::*;
#(
  parameter int MAX_LAYERS = MAX_LAYERS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IN_W-1:0]  in_cell_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [OUT_W-1:0] out_value,
  output logic             out_last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int STORE_DEPTH = cells_above_f(MAX_LAYERS + 1);
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int SUM_W       = VALUE_BITS + $clog2(MAX_LAYERS + 1);
  localparam int LAY_W       = $clog2(MAX_LAYERS + 2);

  logic [CFG_W-1:0] layer_count_r;
  logic [LAY_W-1:0] layers;

  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r;
  logic [OUT_W-1:0] out_value_r;
  logic             out_last_r;

  emit_t                 emit;
  logic                  slot_free;
  logic                  cell_we, best_we;
  logic [IDX_W-1:0]      cell_waddr, cell_raddr, best_waddr, best_raddr;
  logic [VALUE_BITS-1:0] cell_wdata, cell_rdata;
  logic [SUM_W-1:0]      best_wdata, best_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      layer_count_r <= cfg_data;
    end
  end

  always_comb begin
    if (layer_count_r == '0) begin
      layers = LAY_W'(1);
    end else if (layer_count_r > CFG_W'(MAX_LAYERS)) begin
      layers = LAY_W'(MAX_LAYERS);
    end else begin
      layers = LAY_W'(layer_count_r);
    end
  end

  assign slot_free     = !out_valid_r || !out_stall;
  assign out_valid_nxt = (emit.valid && slot_free) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid && slot_free) begin
      out_kind_r  <= emit.kind;
      out_value_r <= emit.value;
      out_last_r  <= emit.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  pmps_seq #(
    .MAX_LAYERS (MAX_LAYERS),
    .VALUE_BITS (VALUE_BITS),
    .STORE_DEPTH(STORE_DEPTH),
    .IDX_W      (IDX_W),
    .SUM_W      (SUM_W),
    .LAY_W      (LAY_W)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cell_value(in_cell_value),
    .layers       (layers),
    .slot_free    (slot_free),
    .emit         (emit),
    .cell_we      (cell_we),
    .cell_waddr   (cell_waddr),
    .cell_wdata   (cell_wdata),
    .cell_raddr   (cell_raddr),
    .cell_rdata   (cell_rdata),
    .best_we      (best_we),
    .best_waddr   (best_waddr),
    .best_wdata   (best_wdata),
    .best_raddr   (best_raddr),
    .best_rdata   (best_rdata)
  );

  pmps_store #(
    .STORE_DEPTH(STORE_DEPTH),
    .IDX_W      (IDX_W),
    .VALUE_BITS (VALUE_BITS),
    .SUM_W      (SUM_W)
  ) u_store (
    .clk       (clk),
    .cell_we   (cell_we),
    .cell_waddr(cell_waddr),
    .cell_wdata(cell_wdata),
    .cell_raddr(cell_raddr),
    .cell_rdata(cell_rdata),
    .best_we   (best_we),
    .best_waddr(best_waddr),
    .best_wdata(best_wdata),
    .best_raddr(best_raddr),
    .best_rdata(best_rdata)
  );

  `PMPS_ASSERT_NOW(a_last_is_path, out_valid_r && out_last_r, out_kind_r == KIND_PATH,
    "last set on a non-path request")
  `PMPS_ASSERT_NOW(a_count_range, out_valid_r && out_kind_r == KIND_COUNT,
    out_value_r != '0 && out_value_r <= OUT_W'(MAX_LAYERS), "layer count out of range")
  `PMPS_ASSERT_NEXT(a_emit_loaded, emit.valid && slot_free,
    out_valid_r && out_kind_r == $past(emit.kind), "emit request not captured")

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// pyramid min path sum testbench
// streams pyramids of cells through the core under several layer counts and
// compares every result against a bottom-up minimum path predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pmps_pkg::*;

  localparam int MAXL = MAX_LAYERS_DEF;
  localparam int DEPTH = MAXL * (MAXL + 1) * (2 * MAXL + 1) / 6;
  localparam int WATCHDOG = 400000;

  typedef struct packed {
    kind_t            kind;
    logic [OUT_W-1:0] value;
    logic             last;
  } result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [IN_W-1:0]  in_cell_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_kind;
  logic [OUT_W-1:0] out_value;
  logic             out_last;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [15:0] cells [DEPTH];
  logic [21:0] best [DEPTH];
  int          loaded;
  logic [5:0]  layer_reg;
  result_t     pending [$];
  int          errors;
  int          idle_cycles;
  int          send_idle_pct;
  int          stall_pct;

  pyramid_min_path_sum_core uut (.*);

  always #10 clk = ~clk;

  function automatic int above(int k);
    int m;
    m = k - 1;
    return m * (m + 1) * (2 * m + 1) / 6;
  endfunction

  function automatic int idx(int k, int r, int c);
    return above(k) + (r - 1) * k + (c - 1);
  endfunction

  function automatic int eff_layers();
    if (layer_reg == 0) return 1;
    if (layer_reg > MAXL) return MAXL;
    return layer_reg;
  endfunction

  // model one accepted request, queue any results it completes
  task automatic predict_cell(logic [15:0] v);
    int n, r, c, k, bj, bl;
    logic [21:0] m, t;
    n = eff_layers();
    if (loaded < DEPTH) cells[loaded] = v;
    loaded = (loaded + 1) & 16'h3fff;
    if (loaded < above(n + 1)) return;
    loaded = 0;
    for (r = 1; r <= n; r++)
      for (c = 1; c <= n; c++) best[idx(n, r, c)] = cells[idx(n, r, c)];
    for (k = n - 1; k >= 1; k--)
      for (r = 1; r <= k; r++)
        for (c = 1; c <= k; c++) begin
          m = best[idx(k + 1, r, c)];
          t = best[idx(k + 1, r, c + 1)];
          if (t < m) m = t;
          t = best[idx(k + 1, r + 1, c)];
          if (t < m) m = t;
          t = best[idx(k + 1, r + 1, c + 1)];
          if (t < m) m = t;
          best[idx(k, r, c)] = cells[idx(k, r, c)] + m;
        end
    pending.push_back('{KIND_COUNT, OUT_W'(n), 1'b0});
    pending.push_back('{KIND_SUM, best[0][OUT_W-1:0], 1'b0});
    pending.push_back('{KIND_PATH, OUT_W'(1), n == 1});
    r = 1;
    c = 1;
    for (k = 2; k <= n; k++) begin
      bj = r;
      bl = c;
      m = best[idx(k, r, c)];
      t = best[idx(k, r, c + 1)];
      if (t < m) begin m = t; bl = c + 1; end
      t = best[idx(k, r + 1, c)];
      if (t < m) begin m = t; bj = r + 1; bl = c; end
      t = best[idx(k, r + 1, c + 1)];
      if (t < m) begin m = t; bj = r + 1; bl = c + 1; end
      r = bj;
      c = bl;
      pending.push_back('{KIND_PATH, OUT_W'(idx(k, r, c) + 1), k == n});
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // valid stays high after acceptance until the next request or an idle phase
  task automatic send_cell(logic [15:0] v);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cell_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_cell(v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() > 0) @(posedge clk);
    repeat (20000) @(posedge clk);
  endtask

  task automatic set_layers(logic [5:0] n);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    layer_reg = n;
  endtask

  task automatic send_pyramid(int kind);
    int n, i;
    n = eff_layers();
    for (i = 0; i < above(n + 1); i++)
      case (kind)
        0: send_cell(16'hffff);
        1: send_cell(16'h0000);
        2: send_cell(16'(i % 3));
        default: send_cell(16'($urandom));
      endcase
  endtask

  task automatic test_directed();
    set_layers(6'd1);
    send_cell(16'hffff);
    send_cell(16'h0000);
    drain();
    set_layers(6'd2);
    send_pyramid(0);
    send_pyramid(1);
    drain();
    set_layers(6'd3);
    send_pyramid(2);
    drain();
    set_layers(6'd0);
    send_cell(16'h5a5a);
    drain();
  endtask

  // counts above the maximum act as the maximum, the load completes once shrunk
  task automatic test_full_size();
    set_layers(6'd63);
    repeat (25) send_cell(16'($urandom));
    drain();
    set_layers(6'd32);
    repeat (10) send_cell(16'($urandom));
    drain();
    set_layers(6'd4);
    send_cell(16'($urandom));
    drain();
  endtask

  // count changed mid load: loaded already past the new total
  task automatic test_shrink_while_loading();
    set_layers(6'd4);
    repeat (10) send_cell(16'($urandom));
    drain();
    set_layers(6'd2);
    send_cell(16'($urandom));
    drain();
  endtask

  task automatic test_random(int phase_send, int phase_stall, int n_items);
    int sent;
    send_idle_pct = phase_send;
    stall_pct = phase_stall;
    sent = 0;
    while (sent < n_items) begin
      set_layers(6'($urandom_range(1, 5)));
      send_pyramid($urandom_range(3) == 0 ? 2 : 3);
      sent += above(eff_layers() + 1);
      drain();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        report("unexpected result", out_value, 0);
      end else begin
        want = pending.pop_front();
        if (out_kind != want.kind) report("kind", out_kind, want.kind);
        if (out_value != want.value) report("value", out_value, want.value);
        if (out_last != want.last) report("last", out_last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    loaded = 0;
    layer_reg = 6'd1;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_shrink_while_loading();
    test_full_size();
    test_random(0, 0, 75);
    test_random(63, 0, 75);
    test_random(0, 63, 75);
    test_random(36, 36, 75);
    if (errors == 0 && pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
